>>> sv/mdb_pkg.sv
// Package: shared constants, codes and types for the MDB block receiver.
`timescale 1ns / 1ps

package mdb_pkg;

   // Buffer geometry
   localparam int BUFFER_DEPTH = 36;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int FILL_W       = 6;

   // Field widths
   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PLAIN  = 3'd0;
   localparam logic [OP_W-1:0] OP_MODE   = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_STATUS = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // Block status codes
   localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RECV   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CHKERR = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVER   = 3'd4;

   // Register index of protocol_mode
   localparam logic REG_PROTOCOL_MODE = 1'b0;

   // Per-transaction result from the control stage (data byte comes from the RAM)
   typedef struct packed {
      logic                reply_valid;
      logic                reply_nak;
      logic                data_valid;
      logic [STATUS_W-1:0] rx_status;
      logic [FILL_W-1:0]   fill_count;
   } result_type;

endpackage

>>> sv/mdb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mdb_ctrl.sv
// Control stage: indices, running sum, block status and ACK/NAK decisions.
`timescale 1ns / 1ps

module mdb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          protocol_mode,
   input  logic [mdb_pkg::OP_W-1:0]      op,
   input  logic [mdb_pkg::BYTE_W-1:0]    rx_byte,
   output logic                          ram_wr_en,
   output logic [mdb_pkg::ADDR_W-1:0]    ram_wr_addr,
   output logic                          ram_rd_en,
   output logic [mdb_pkg::ADDR_W-1:0]    ram_rd_addr,
   output mdb_pkg::result_type           result
);
   import mdb_pkg::*;

   logic [IDX_W-1:0]    write_index_ff, write_index_in;
   logic [IDX_W-1:0]    read_index_ff, read_index_in;
   logic [STATUS_W-1:0] block_status_ff, block_status_in;
   logic [BYTE_W-1:0]   running_sum_ff, running_sum_in;

   logic                mdb;
   logic                room;
   logic                put;
   logic [IDX_W-1:0]    read_next;

   assign mdb       = (protocol_mode == 1'b0);
   assign room      = (write_index_ff < IDX_W'(BUFFER_DEPTH));
   assign read_next = read_index_ff + IDX_W'(1);

   // Next-state and reply decode for one transaction
   always_comb begin
      write_index_in     = write_index_ff;
      read_index_in      = read_index_ff;
      block_status_in    = block_status_ff;
      running_sum_in     = running_sum_ff;
      put                = 1'b0;
      ram_rd_en          = 1'b0;
      result.reply_valid = 1'b0;
      result.reply_nak   = 1'b0;
      result.data_valid  = 1'b0;
      unique case (op)
         OP_PLAIN: begin
            if (room) begin
               put = 1'b1;
               if (mdb) begin
                  block_status_in = ST_RECV;
                  running_sum_in  = ((block_status_ff == ST_IDLE) ? '0 : running_sum_ff)
                                    + rx_byte;
               end
            end else if (mdb) begin
               block_status_in    = ST_OVER;
               result.reply_valid = 1'b1;
               result.reply_nak   = 1'b1;
            end
         end
         OP_MODE: begin
            if (mdb) begin
               if (block_status_ff == ST_IDLE) begin
                  // lone byte: stored if it fits, acknowledged either way
                  put                = room;
                  block_status_in    = ST_OK;
                  result.reply_valid = 1'b1;
               end else if (block_status_ff == ST_RECV) begin
                  result.reply_valid = 1'b1;
                  if (room) begin
                     put = 1'b1;
                     if (rx_byte == running_sum_ff) begin
                        block_status_in = ST_OK;
                     end else begin
                        block_status_in  = ST_CHKERR;
                        result.reply_nak = 1'b1;
                     end
                  end else begin
                     block_status_in  = ST_OVER;
                     result.reply_nak = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            if (read_index_ff < write_index_ff) begin
               ram_rd_en         = 1'b1;
               result.data_valid = 1'b1;
               if (read_next == write_index_ff) begin
                  read_index_in  = '0;
                  write_index_in = '0;
               end else begin
                  read_index_in = read_next;
               end
            end
         end
         OP_STATUS: begin
            block_status_in = ST_IDLE;
         end
         OP_CLEAR: begin
            write_index_in  = '0;
            read_index_in   = '0;
            block_status_in = ST_IDLE;
         end
         default: begin
         end
      endcase
      if (put) begin
         write_index_in = write_index_ff + IDX_W'(1);
      end
      // Status read reports the value before it is cleared
      result.rx_status  = (op == OP_STATUS) ? block_status_ff : block_status_in;
      result.fill_count = (write_index_in >= read_index_in) ?
                          FILL_W'(write_index_in - read_index_in) : '0;
   end

   assign ram_wr_en   = accept & put;
   assign ram_wr_addr = write_index_ff[ADDR_W-1:0];
   assign ram_rd_addr = read_index_ff[ADDR_W-1:0];

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff  <= '0;
         read_index_ff   <= '0;
         block_status_ff <= ST_IDLE;
         running_sum_ff  <= '0;
      end else if (accept) begin
         write_index_ff  <= write_index_in;
         read_index_ff   <= read_index_in;
         block_status_ff <= block_status_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

>>> sv/mdb_block_receiver.sv
// Top level: MDB block receiver with buffer RAM, CSR port and result pipeline.
`timescale 1ns / 1ps

// The receiver takes one transaction per clock unless stalled by the result side (a
// received byte, a byte with the mode bit, a buffer read, a status read or a clear)
// and returns exactly one result per transaction via stage 1 and the output register.
// All indices, status, running sum and ACK/NAK decisions are updated in the cycle
// the transaction is accepted; stage 1 holds the result fields while the registered
// read of the 36-entry byte buffer RAM completes. A holding stage ahead of the output
// register lets new transactions be taken while a result waits. protocol_mode sits
// at CSR address 0 and should be written only while the block is idle.

module mdb_block_receiver (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mdb_pkg::OP_W-1:0]          req_op,
   input  logic [mdb_pkg::BYTE_W-1:0]        req_rx_byte,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_reply_valid,
   output logic                              rsp_reply_nak,
   output logic                              rsp_data_valid,
   output logic [mdb_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic [mdb_pkg::STATUS_W-1:0]      rsp_rx_status,
   output logic [mdb_pkg::FILL_W-1:0]        rsp_fill_count,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mdb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mdb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mdb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mdb_pkg::*;

   logic protocol_mode_ff;
   logic csr_sel_mode;

   logic accept;
   logic s1_move;
   logic s2_load;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [BYTE_W-1:0]   ram_rd_data;
   result_type          ctrl_result;

   logic                s1_valid_ff;
   result_type          s1_result_ff;
   logic                s2_valid_ff;
   result_type          s2_result_ff;
   logic [BYTE_W-1:0]   s2_data_ff;

   // CSR access
   assign csr_pready   = 1'b1;
   assign csr_sel_mode = (csr_paddr[CSR_ADDR_W-1] == REG_PROTOCOL_MODE);
   assign csr_prdata   = csr_sel_mode ? CSR_DATA_W'(protocol_mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_mode) begin
         protocol_mode_ff <= csr_pwdata[0];
      end
   end

   // Handshake: s2 is the output register, s1 holds a transaction whose RAM read is pending
   assign s2_load   = !s2_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_load;
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   mdb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .protocol_mode (protocol_mode_ff),
      .op            (req_op),
      .rx_byte       (req_rx_byte),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .result        (ctrl_result)
   );

   mdb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (accept && ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stage 1: result fields wait here while the RAM read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= ctrl_result;
      end
   end

   // Stage 2: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_result_ff <= s1_result_ff;
         s2_data_ff   <= s1_result_ff.data_valid ? ram_rd_data : '0;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_reply_valid = s2_result_ff.reply_valid;
   assign rsp_reply_nak   = s2_result_ff.reply_nak;
   assign rsp_data_valid  = s2_result_ff.data_valid;
   assign rsp_data_byte   = s2_data_ff;
   assign rsp_rx_status   = s2_result_ff.rx_status;
   assign rsp_fill_count  = s2_result_ff.fill_count;

endmodule
